@@ src/dmf_pkg.sv @@
`timescale 1ns / 1ps

package dmf_pkg;

	localparam int KERNEL_SIZE_DEF = 3;
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int MAX_HEIGHT      = 1024;

	localparam int PIX_W     = 16;
	localparam int COORD_W   = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef logic signed [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic               emit;
		logic               border;
		logic               last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} meta_t;

endpackage

@@ src/dmf_ram.sv @@
`timescale 1ns / 1ps

module dmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/depth_median_filter_core.sv @@
`timescale 1ns / 1ps
// Streaming KERNEL_SIZE x KERNEL_SIZE median filter for signed depth pixels.
// Throughput: one item per cycle unless out_ready stalls; each item writes one line
// memory, all are read as stage 1 advances. Each result leaves the output register and
// belongs to the pixel R rows and R columns behind its item (R = KERNEL_SIZE/2).
// Reset (arst_n low, asynchronous): counters to frame start, size 640 x 480, pipeline empty.
// Line memories are not cleared; stale rows feed only border results, set to zero.

module depth_median_filter_core #(
	parameter int KERNEL_SIZE = dmf_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = dmf_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_we,
	input  logic [dmf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dmf_pkg::CFG_W-1:0]        cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  dmf_pkg::pix_t                    depth_in,

	output logic                             out_valid,
	input  logic                             out_ready,
	output dmf_pkg::pix_t                    depth_out,
	output logic [dmf_pkg::COORD_W-1:0]      out_row,
	output logic [dmf_pkg::COORD_W-1:0]      out_col,
	output logic                             frame_last
);

	localparam int R   = KERNEL_SIZE / 2;
	localparam int N   = KERNEL_SIZE * KERNEL_SIZE;
	localparam int MID = N / 2;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = dmf_pkg::COORD_W;
	localparam int HW  = $clog2(dmf_pkg::MAX_HEIGHT + 1);
	localparam int SW  = $clog2(KERNEL_SIZE);
	localparam int NW  = $clog2(N + 1);
	localparam int XW  = (WW > dmf_pkg::COORD_W) ? WW : dmf_pkg::COORD_W;
	localparam int DW  = (WW > dmf_pkg::CFG_W) ? WW : dmf_pkg::CFG_W;
	localparam int HDW = (HW > dmf_pkg::CFG_W) ? HW : dmf_pkg::CFG_W;
	localparam int RST_W = (dmf_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
		: dmf_pkg::RESET_WIDTH;

	// configuration, stored already clamped
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [DW-1:0] cfg_wx;
	logic [HDW-1:0] cfg_hx;
	logic [WW-1:0] w_new;
	logic [HW-1:0] h_new;

	always_comb begin
		cfg_wx = DW'(cfg_data);
		cfg_hx = HDW'(cfg_data);
		if (cfg_wx < DW'(KERNEL_SIZE)) begin
			w_new = WW'(KERNEL_SIZE);
		end else if (cfg_wx > DW'(MAX_WIDTH)) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = cfg_wx[WW-1:0];
		end
		if (cfg_hx < HDW'(KERNEL_SIZE)) begin
			h_new = HW'(KERNEL_SIZE);
		end else if (cfg_hx > HDW'(dmf_pkg::MAX_HEIGHT)) begin
			h_new = HW'(dmf_pkg::MAX_HEIGHT);
		end else begin
			h_new = cfg_hx[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(RST_W);
			h_q <= HW'(dmf_pkg::RESET_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				dmf_pkg::REG_WIDTH:  w_q <= w_new;
				dmf_pkg::REG_HEIGHT: h_q <= h_new;
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en1, en2, en3, en_o;
	logic accept;

	assign en_o     = !out_valid_q || out_ready;
	assign en3      = !v_s3 || en_o;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && en1;

	// raster position of the accepted item
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] slot_q;

	logic          col_wrap, row_wrap, hi_c;
	logic [CW-1:0] c_cur;
	logic [HW-1:0] row_inc;
	logic [RW-1:0] r_cur;
	logic [SW-1:0] slot_inc, slot_cur, slot_adv;
	logic [WW-1:0] col_nxt;
	logic [HW-1:0] row_nxt;
	logic [XW-1:0] ocol_x;
	dmf_pkg::meta_t meta_d;

	always_comb begin
		col_wrap = WW'(col_q) >= w_q;
		c_cur    = col_wrap ? '0 : col_q;
		row_inc  = col_wrap ? HW'(row_q) + HW'(1) : HW'(row_q);
		row_wrap = row_inc >= h_q;
		r_cur    = row_wrap ? '0 : row_inc[RW-1:0];
		if (col_wrap) begin
			slot_inc = (slot_q == SW'(KERNEL_SIZE - 1)) ? '0 : slot_q + SW'(1);
		end else begin
			slot_inc = slot_q;
		end
		slot_cur = row_wrap ? '0 : slot_inc;
		slot_adv = (slot_cur == SW'(KERNEL_SIZE - 1)) ? '0 : slot_cur + SW'(1);
		col_nxt  = WW'(c_cur) + WW'(1);
		row_nxt  = HW'(r_cur) + HW'(1);

		hi_c = c_cur >= CW'(R);
		if (hi_c) begin
			ocol_x     = XW'(c_cur) - XW'(R);
			meta_d.row = r_cur - RW'(R);
		end else begin
			ocol_x     = XW'(c_cur) + XW'(w_q) - XW'(R);
			meta_d.row = r_cur - RW'(R + 1);
		end
		meta_d.col    = ocol_x[dmf_pkg::COORD_W-1:0];
		meta_d.emit   = (r_cur > RW'(R)) || (r_cur == RW'(R) && hi_c);
		meta_d.border = !(c_cur >= CW'(2 * R) && r_cur >= RW'(2 * R));
		meta_d.last   = (WW'(c_cur) == w_q - WW'(1)) && (HW'(r_cur) == h_q - HW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (col_nxt >= w_q) begin
				col_q <= '0;
				if (row_nxt >= h_q) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_nxt[RW-1:0];
					slot_q <= slot_adv;
				end
			end else begin
				col_q  <= col_nxt[CW-1:0];
				row_q  <= r_cur;
				slot_q <= slot_cur;
			end
		end
	end

	// line memories, one per row slot
	dmf_pkg::pix_t rd_data [KERNEL_SIZE];

	for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_line
		dmf_ram #(
			.WIDTH (dmf_pkg::PIX_W),
			.DEPTH (MAX_WIDTH)
		) u_line (
			.clk   (clk),
			.we    (accept && slot_cur == SW'(k)),
			.waddr (c_cur),
			.wdata (depth_in),
			.re    (en1),
			.raddr (c_cur),
			.rdata (rd_data[k])
		);
	end

	// stage 1: memory read data and current pixel
	dmf_pkg::pix_t  pix_s1;
	logic [SW-1:0]  slot_s1;
	dmf_pkg::meta_t meta_s1;
	dmf_pkg::pix_t  col_s1 [KERNEL_SIZE];

	always_comb begin
		logic [SW:0] idx;
		idx = '0;
		for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
			idx = {1'b0, slot_s1} + (SW + 1)'(i + 1);
			if (idx >= (SW + 1)'(KERNEL_SIZE)) begin
				idx = idx - (SW + 1)'(KERNEL_SIZE);
			end
			col_s1[i] = rd_data[idx[SW-1:0]];
		end
		col_s1[KERNEL_SIZE-1] = pix_s1;
	end

	// stage 2: window, column 0 oldest, row 0 topmost
	dmf_pkg::pix_t  win_s2 [KERNEL_SIZE][KERNEL_SIZE];
	dmf_pkg::meta_t meta_s2;
	logic [N-1:0]   lt_d [N];

	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				lt_d[i][j] = win_s2[j / KERNEL_SIZE][j % KERNEL_SIZE]
					< win_s2[i / KERNEL_SIZE][i % KERNEL_SIZE];
			end
		end
	end

	// stage 3: compare matrix; lt_s3[i][j] set when element j is below element i
	logic [N-1:0]   lt_s3 [N];
	dmf_pkg::pix_t  wv_s3 [N];
	dmf_pkg::meta_t meta_s3;

	// median: an element with at most MID below it and more than MID at or below it
	logic [N-1:0]         gt_v [N];
	logic [NW-1:0]        cnt_lt, cnt_gt;
	logic [dmf_pkg::PIX_W-1:0] med;

	always_comb begin
		med = '0;
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				gt_v[i][j] = lt_s3[j][i];
			end
		end
		for (int i = 0; i < N; i++) begin
			cnt_lt = NW'($countones(lt_s3[i]));
			cnt_gt = NW'($countones(gt_v[i]));
			if (cnt_lt <= NW'(MID) && cnt_gt < NW'(N - MID)) begin
				med = med | wv_s3[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_o) begin
				out_valid_q <= v_s3 && meta_s3.emit;
			end
		end
	end

	dmf_pkg::pix_t             depth_out_q;
	logic [dmf_pkg::COORD_W-1:0] out_row_q, out_col_q;
	logic                      frame_last_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= depth_in;
			slot_s1 <= slot_cur;
			meta_s1 <= meta_d;
		end
		if (en2 && v_s1) begin
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
					win_s2[i][j] <= win_s2[i][j+1];
				end
				win_s2[i][KERNEL_SIZE-1] <= col_s1[i];
			end
			meta_s2 <= meta_s1;
		end
		if (en3 && v_s2) begin
			for (int i = 0; i < N; i++) begin
				lt_s3[i] <= lt_d[i];
				wv_s3[i] <= win_s2[i / KERNEL_SIZE][i % KERNEL_SIZE];
			end
			meta_s3 <= meta_s2;
		end
		if (en_o && v_s3) begin
			depth_out_q  <= meta_s3.border ? '0 : med;
			out_row_q    <= meta_s3.row;
			out_col_q    <= meta_s3.col;
			frame_last_q <= meta_s3.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign depth_out  = depth_out_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_last = frame_last_q;

	logic [XW-1:0] last_col_x;
	assign last_col_x = XW'(w_q) - XW'(R + 1);

	a_top_rows_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_row < dmf_pkg::COORD_W'(R) |-> depth_out == '0)
		else $error("top border row with nonzero depth");

	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> out_col == last_col_x[dmf_pkg::COORD_W-1:0])
		else $error("frame_last away from last interior column");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < SW'(KERNEL_SIZE) && HW'(row_q) < HW'(dmf_pkg::MAX_HEIGHT))
		else $error("raster position out of range");

endmodule
